// ===== design/hrpt_frame_sync_deframer_unit_macros.svh =====
// assertion macros used by the checker of the deframer
`ifndef HRPT_FRAME_SYNC_DEFRAMER_UNIT_MACROS_SVH
`define HRPT_FRAME_SYNC_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HFSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define HFSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hfsd_pkg.sv =====
package hfsd_pkg;

  localparam int FRAME_WORDS  = 11090;
  localparam int IMAGE_OFFSET = 750;
  localparam int NUM_CHANNELS = 5;
  localparam int SCAN_WIDTH   = 2048;
  localparam int SYNC_LEN     = 6;
  localparam int IMAGE_WORDS  = SCAN_WIDTH * NUM_CHANNELS;
  localparam int IMAGE_END    = IMAGE_OFFSET + IMAGE_WORDS;

  localparam int POS_W    = 14;
  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 11;
  localparam int PIXEL_W  = 10;
  localparam int FRAME_W  = 16;
  localparam int MATCH_W  = 3;
  localparam int INDEX_W  = 4;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_LITTLE_ENDIAN = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] REG_NORTH_BOUND   = INDEX_W'(1);

  typedef struct packed {
    logic [PIXEL_W-1:0]  pixel;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
    logic [FRAME_W-1:0]  frame_index;
    logic                line_end;
  } result_t;

  function automatic logic [15:0] sync_word(input logic [MATCH_W-1:0] idx);
    logic [15:0] w;
    unique case (idx)
      3'd0:    w = 16'h0284;
      3'd1:    w = 16'h016F;
      3'd2:    w = 16'h035C;
      3'd3:    w = 16'h019D;
      3'd4:    w = 16'h020F;
      3'd5:    w = 16'h0095;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

// ===== design/hrpt_frame_sync_deframer_unit.sv =====
// Minor frame deframer: one byte pair per item, one item accepted per clock. While hunting
// it looks for the six-word frame sync; after it locks, it counts word positions through an
// 11090-word frame and turns each image word (positions 750 to 10989) into a result carrying
// the 10-bit pixel, channel, scan line sample, frame count and an end-of-line flag on the
// last image word. Each result is registered in the output register, or in the skid register
// while the output is held. The frame state updates once per accepted item, and a two-entry
// output buffer (output register plus skid register) lets input keep flowing while a result
// waits; input stalls only when both entries are full. Configuration writes are always ready
// and take effect with the next item.
module hrpt_frame_sync_deframer_unit
  import hfsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          first_byte,
  input  logic [7:0]          second_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PIXEL_W-1:0]  pixel,
  output logic [CHAN_W-1:0]   channel,
  output logic [SAMPLE_W-1:0] sample,
  output logic [FRAME_W-1:0]  frame_index,
  output logic                line_end
);

  localparam logic [POS_W-1:0]    POS_SYNC_DONE = POS_W'(SYNC_LEN);
  localparam logic [POS_W-1:0]    POS_IMG_FIRST = POS_W'(IMAGE_OFFSET);
  localparam logic [POS_W-1:0]    POS_IMG_END   = POS_W'(IMAGE_END);
  localparam logic [POS_W-1:0]    POS_IMG_LAST  = POS_W'(IMAGE_END - 1);
  localparam logic [POS_W-1:0]    POS_FRAME_END = POS_W'(FRAME_WORDS - 1);
  localparam logic [CHAN_W-1:0]   CHAN_LAST     = CHAN_W'(NUM_CHANNELS - 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_LAST   = SAMPLE_W'(SCAN_WIDTH - 1);
  localparam logic [MATCH_W-1:0]  MATCH_FULL    = MATCH_W'(SYNC_LEN);

  logic                little_endian;
  logic                north_bound;
  logic [MATCH_W-1:0]  sync_matched;
  logic                locked;
  logic [POS_W-1:0]    word_position;
  logic [FRAME_W-1:0]  frames_found;
  logic [CHAN_W-1:0]   channel_counter;
  logic [SAMPLE_W-1:0] sample_counter;

  logic [MATCH_W-1:0]  sync_matched_next;
  logic                locked_next;
  logic [POS_W-1:0]    word_position_next;
  logic [FRAME_W-1:0]  frames_found_next;
  logic [CHAN_W-1:0]   channel_counter_next;
  logic [SAMPLE_W-1:0] sample_counter_next;

  logic                out_full;
  result_t             out_reg;
  logic                skid_valid;
  result_t             skid_reg;

  logic                accept;
  logic                take;
  logic [15:0]         word;
  logic [MATCH_W-1:0]  m_base;
  logic [MATCH_W-1:0]  m_new;
  logic                in_image;
  logic                emit;
  result_t             res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign take      = out_full && !out_stall;

  assign out_valid   = out_full;
  assign pixel       = out_reg.pixel;
  assign channel     = out_reg.channel;
  assign sample      = out_reg.sample;
  assign frame_index = out_reg.frame_index;
  assign line_end    = out_reg.line_end;

  assign word = little_endian ? {second_byte, first_byte} : {first_byte, second_byte};
  assign in_image = (word_position >= POS_IMG_FIRST) && (word_position < POS_IMG_END);
  assign emit = accept && locked && in_image;

  always_comb begin
    res.pixel       = word[PIXEL_W-1:0];
    res.channel     = channel_counter;
    res.sample      = north_bound ? (SAMPLE_LAST - sample_counter) : sample_counter;
    res.frame_index = frames_found;
    res.line_end    = (word_position == POS_IMG_LAST);
  end

  always_comb begin
    sync_matched_next    = sync_matched;
    locked_next          = locked;
    word_position_next   = word_position;
    frames_found_next    = frames_found;
    channel_counter_next = channel_counter;
    sample_counter_next  = sample_counter;
    m_base = (sync_matched >= MATCH_FULL) ? '0 : sync_matched;
    if (word == sync_word(m_base)) begin
      m_new = m_base + MATCH_W'(1);
    end else begin
      // a broken match may restart on this same word
      m_new = (word == sync_word('0)) ? MATCH_W'(1) : '0;
    end
    if (accept) begin
      if (!locked) begin
        if (m_new == MATCH_FULL) begin
          locked_next          = 1'b1;
          word_position_next   = POS_SYNC_DONE;
          channel_counter_next = '0;
          sample_counter_next  = '0;
          sync_matched_next    = '0;
        end else begin
          sync_matched_next = m_new;
        end
      end else begin
        if (in_image) begin
          if (channel_counter >= CHAN_LAST) begin
            channel_counter_next = '0;
            sample_counter_next  = sample_counter + SAMPLE_W'(1);
          end else begin
            channel_counter_next = channel_counter + CHAN_W'(1);
          end
        end
        if (word_position >= POS_FRAME_END) begin
          locked_next        = 1'b0;
          word_position_next = '0;
          sync_matched_next  = '0;
          if (frames_found != '1) begin
            frames_found_next = frames_found + FRAME_W'(1);
          end
        end else begin
          word_position_next = word_position + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian   <= 1'b1;
      north_bound     <= 1'b0;
      sync_matched    <= '0;
      locked          <= 1'b0;
      word_position   <= '0;
      frames_found    <= '0;
      channel_counter <= '0;
      sample_counter  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LITTLE_ENDIAN) begin
          little_endian <= cfg_data;
        end
        if (cfg_index == REG_NORTH_BOUND) begin
          north_bound <= cfg_data;
        end
      end
      sync_matched    <= sync_matched_next;
      locked          <= locked_next;
      word_position   <= word_position_next;
      frames_found    <= frames_found_next;
      channel_counter <= channel_counter_next;
      sample_counter  <= sample_counter_next;
    end
  end

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_full   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_full || take) begin
      out_full <= emit;
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_reg <= skid_reg;
      end
    end else if (!out_full || take) begin
      if (emit) begin
        out_reg <= res;
      end
    end else if (emit) begin
      skid_reg <= res;
    end
  end

endmodule

// ===== design/hfsd_checker.sv =====
`include "hrpt_frame_sync_deframer_unit_macros.svh"

module hfsd_checker
  import hfsd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [PIXEL_W-1:0]  pixel,
  input logic [CHAN_W-1:0]   channel,
  input logic [SAMPLE_W-1:0] sample,
  input logic [FRAME_W-1:0]  frame_index,
  input logic                line_end
);

  localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(NUM_CHANNELS - 1);

  // a waiting item stays put
  `HFSD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pixel) && $stable(sample) && $stable(frame_index), "stalled output item changed")

  // input only stalls while the output register is full
  `HFSD_ASSERT_NOW(a_stall_needs_full, clk, rst, in_stall, out_valid, "input stalled with empty output")

  `HFSD_ASSERT_NOW(a_channel_range, clk, rst, out_valid, channel <= CHAN_LAST, "channel out of range")

  // last image word closes a full channel group
  `HFSD_ASSERT_NOW(a_line_end_chan, clk, rst, out_valid && line_end, channel == CHAN_LAST, "line end on wrong channel")

endmodule

bind hrpt_frame_sync_deframer_unit hfsd_checker u_hfsd_checker (.*);
